// ----- rtl/pfcu_pkg.sv -----
// Shared types and constants for the Pauli frame Clifford update block.
// Depends on nothing; every other file of the block imports it.
package pfcu_pkg;

  localparam int QUBIT_COUNT = 256;
  localparam int BATCH      = 64;
  localparam int ADDR_W     = (QUBIT_COUNT > 1) ? $clog2(QUBIT_COUNT) : 1;

  localparam int IN_BITS  = 87;
  localparam int IN_BYTES = (IN_BITS + 7) / 8;
  localparam int OUT_BYTES = 9;

  typedef logic [BATCH-1:0]  word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [4:0] {
    F_NOP, F_H, F_H_XY, F_H_YZ, F_C_XYZ, F_C_ZYX,
    F_CX, F_CY, F_CZ, F_XCX, F_XCY, F_XCZ, F_YCX, F_YCY, F_YCZ,
    F_SQRT_XX, F_SQRT_YY, F_SQRT_ZZ, F_SWAP, F_ISWAP, F_CXSWAP, F_SWAPCX,
    F_MX, F_MY, F_MZ, F_MRX, F_MRY, F_MRZ,
    F_RX, F_RY, F_RZ, F_ERROR
  } func_t;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic        error_on_z;
    logic        error_on_x;
    logic [63:0] error_mask;
    logic [7:0]  qubit_b;
    logic [7:0]  qubit_a;
    func_t       func;
  } item_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic wr_a;
    logic wr_b;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_pair;
    logic is_meas;
  } sts_t;

endpackage

// ----- rtl/pfcu_dp.sv -----
// Datapath: item registers, frame store with per-entry valid bits,
// gate update logic and the result register. Depends on pfcu_pkg.
module pfcu_dp import pfcu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [63:0] out_flips,
  output logic [7:0]  out_qubit
);

  func_t       func_q;
  logic [7:0]  qa_q;
  logic [7:0]  qb_q;
  word_t       mask_q;
  logic        ex_q;
  logic        ez_q;

  word_t x_mem [QUBIT_COUNT];
  word_t z_mem [QUBIT_COUNT];
  logic [QUBIT_COUNT-1:0] valid;

  word_t xa_rd, za_rd, xb_rd, zb_rd;
  logic  va_rd, vb_rd;

  word_t x1, z1, x2, z2, d, e, tmp, flips;
  word_t wx, wz;
  addr_t addr_a, addr_b, waddr;
  logic  a_ok, b_ok, we;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= item.func;
      qa_q   <= item.qubit_a;
      qb_q   <= item.qubit_b;
      mask_q <= item.error_mask[BATCH-1:0];
      ex_q   <= item.error_on_x;
      ez_q   <= item.error_on_z;
    end
  end

  assign addr_a = ADDR_W'(qa_q);
  assign addr_b = ADDR_W'(qb_q);
  assign a_ok   = int'(qa_q) < QUBIT_COUNT;
  assign b_ok   = int'(qb_q) < QUBIT_COUNT;

  assign sts.is_meas = func_q inside {[F_MX:F_MRZ]};
  assign sts.is_pair = func_q inside {[F_CX:F_SWAPCX]};

  // Read both targets when the item is taken; the read data then holds
  // for the whole item because no other read is issued.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      xa_rd <= x_mem[ADDR_W'(item.qubit_a)];
      za_rd <= z_mem[ADDR_W'(item.qubit_a)];
      xb_rd <= x_mem[ADDR_W'(item.qubit_b)];
      zb_rd <= z_mem[ADDR_W'(item.qubit_b)];
      va_rd <= valid[ADDR_W'(item.qubit_a)];
      vb_rd <= valid[ADDR_W'(item.qubit_b)];
    end
    if (we) begin
      x_mem[waddr] <= wx;
      z_mem[waddr] <= wz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_comb begin
    x1 = va_rd ? xa_rd : '0;
    z1 = va_rd ? za_rd : '0;
    x2 = vb_rd ? xb_rd : '0;
    z2 = vb_rd ? zb_rd : '0;
    d = '0;
    e = '0;
    tmp = '0;
    flips = '0;
    case (func_q)
      F_H:       begin tmp = x1; x1 = z1; z1 = tmp; end
      F_H_XY:    z1 ^= x1;
      F_H_YZ:    x1 ^= z1;
      F_C_XYZ:   begin x1 ^= z1; z1 ^= x1; end
      F_C_ZYX:   begin z1 ^= x1; x1 ^= z1; end
      F_CX:      begin z1 ^= z2; x2 ^= x1; end
      F_CY:      begin z1 ^= x2 ^ z2; z2 ^= x1; x2 ^= x1; end
      F_CZ:      begin z1 ^= x2; z2 ^= x1; end
      F_XCX:     begin x1 ^= z2; x2 ^= z1; end
      F_XCY:     begin x1 ^= x2 ^ z2; x2 ^= z1; z2 ^= z1; end
      F_XCZ:     begin z2 ^= z1; x1 ^= x2; end
      F_YCX:     begin x2 ^= x1 ^ z1; x1 ^= z2; z1 ^= z2; end
      F_YCY:     begin
        d = x1 ^ z1;
        e = x2 ^ z2;
        x1 ^= e; z1 ^= e; x2 ^= d; z2 ^= d;
      end
      F_YCZ:     begin z2 ^= x1 ^ z1; z1 ^= x2; x1 ^= x2; end
      F_SQRT_XX: begin d = z1 ^ z2; x1 ^= d; x2 ^= d; end
      F_SQRT_YY: begin
        d = x1 ^ z1 ^ x2 ^ z2;
        x1 ^= d; z1 ^= d; x2 ^= d; z2 ^= d;
      end
      F_SQRT_ZZ: begin d = x1 ^ x2; z1 ^= d; z2 ^= d; end
      F_SWAP:    begin
        tmp = x1; x1 = x2; x2 = tmp;
        tmp = z1; z1 = z2; z2 = tmp;
      end
      F_ISWAP:   begin
        d = x1 ^ x2;
        tmp = z1 ^ d; z1 = z2 ^ d; z2 = tmp;
        tmp = x1; x1 = x2; x2 = tmp;
      end
      F_CXSWAP:  begin z2 ^= z1; z1 ^= z2; x1 ^= x2; x2 ^= x1; end
      F_SWAPCX:  begin z1 ^= z2; z2 ^= z1; x2 ^= x1; x1 ^= x2; end
      F_MX:      flips = z1;
      F_MY:      flips = x1 ^ z1;
      F_MZ:      flips = x1;
      F_MRX:     begin flips = z1; z1 = '0; end
      F_MRY:     begin flips = x1 ^ z1; x1 = z1; end
      F_MRZ:     begin flips = x1; x1 = '0; end
      F_RX:      z1 = '0;
      F_RY:      x1 = z1;
      F_RZ:      x1 = '0;
      F_ERROR:   begin
        if (ex_q) x1 ^= mask_q;
        if (ez_q) z1 ^= mask_q;
      end
      default:   ;
    endcase
  end

  // A pair gate with either target out of range changes nothing.
  assign we    = (cmd.wr_a && a_ok && (!sts.is_pair || b_ok)) ||
                 (cmd.wr_b && a_ok && b_ok);
  assign waddr = cmd.wr_b ? addr_b : addr_a;
  assign wx    = cmd.wr_b ? x2 : x1;
  assign wz    = cmd.wr_b ? z2 : z1;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_flips <= a_ok ? 64'(flips) : 64'd0;
      out_qubit <= qa_q;
    end
  end

endmodule

// ----- rtl/pfcu_ctrl.sv -----
// Controller: sequences read, write-back of one or two qubits and the
// result handshake. Depends on pfcu_pkg.
module pfcu_ctrl import pfcu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {IDLE, EXEC, WR_B} state_t;

  state_t state;
  state_t state_next;
  logic   stall;

  assign s_tready = (state == IDLE);
  assign stall    = sts.is_meas && m_tvalid && !m_tready;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = EXEC;
      end
      EXEC: begin
        if (!stall) begin
          cmd.wr_a     = 1'b1;
          cmd.load_out = sts.is_meas;
          state_next   = sts.is_pair ? WR_B : IDLE;
        end
      end
      WR_B: begin
        cmd.wr_b   = 1'b1;
        state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= cmd.load_out || (m_tvalid && !m_tready);
    end
  end

`ifndef SYNTHESIS
  a_wrb_after_wra: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_b |-> $past(cmd.wr_a))
    else $error("second write-back without a first");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(m_tvalid && !m_tready))
    else $error("result register overwritten while waiting");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == EXEC)
    else $error("accepted item not executed");
`endif

endmodule

// ----- rtl/pauli_frame_clifford_update_top.sv -----
// Top level of the Pauli frame Clifford update block: stream ports,
// controller and datapath. Depends on pfcu_pkg, pfcu_ctrl and pfcu_dp.
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid / s_tready  s_tdata, 88 bits: one gate item
//   m_*       out  m_tvalid / m_tready  m_tdata, 72 bits: one measurement
//
// A single-qubit gate, reset, error or measurement reads the frame store
// when it is taken, then updates and writes back. A two-qubit gate adds a
// second write-back, because the frame store has a single write port and
// both qubits' words are written back in turn.
// Reset (rst, synchronous) clears the per-qubit valid bits at once, so the
// whole store reads as zero once reset ends; no clearing pass is run.
// A measurement waits in its update cycle while an earlier result is still
// held in the output register; a new item can be taken while a result waits.
module pauli_frame_clifford_update_top import pfcu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // func[4:0], qubit_a[12:5], qubit_b[20:13], error_mask[84:21],
  // error_on_x[85], error_on_z[86], zero pad[87]
  input  logic [8*IN_BYTES-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // measured_flips[63:0], measured_qubit[71:64]
  output logic [8*OUT_BYTES-1:0] m_tdata
);

  item_t       item;
  cmd_t        cmd;
  sts_t        sts;
  logic [63:0] out_flips;
  logic [7:0]  out_qubit;

  // The pad bit above the last field carries nothing.
  assign item    = item_t'(s_tdata[IN_BITS-1:0]);
  assign m_tdata = {out_qubit, out_flips};

  pfcu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfcu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_flips (out_flips),
    .out_qubit (out_qubit)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for pauli_frame_clifford_update_top: a scripted gate
// sequence, then random gate streams, each checked against an in-bench frame model.
// Depends on pfcu_pkg and the RTL of the block; reads no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pfcu_pkg::*;

  // One measurement result: the flip word and the qubit it belongs to.
  typedef struct packed {
    word_t      flips;
    logic [7:0] qubit;
  } meas_t;

  // One row of the directed script. When pinned is set, the measurement
  // result is the hand-written flips value instead of the model's.
  typedef struct packed {
    func_t      f;
    logic [7:0] qa;
    logic [7:0] qb;
    word_t      mask;
    logic       ex;
    logic       ez;
    logic       pinned;
    word_t      flips;
  } gate_row_t;

  localparam word_t NONE = '0;
  localparam word_t ONES = '1;
  localparam word_t ALT  = 64'h5555_5555_5555_5555;
  localparam word_t HI   = 64'hF0F0_F0F0_F0F0_F0F0;
  localparam int    SCRIPT_LEN = 38;
  localparam int    RANDOM_ITEMS = 600;
  localparam int    IDLE_PCT = 29;

  // The directed part. Qubits 1 and 2 carry distinct X and Z patterns
  // before the gate walk, so most gates below change something visible.
  localparam gate_row_t SCRIPT [SCRIPT_LEN] = '{
    // Fresh store: every qubit reads as zero after reset.
    '{F_MZ,      8'd0,   8'd0,   NONE, 1'b0, 1'b0, 1'b1, NONE},
    '{F_MY,      8'd255, 8'd0,   NONE, 1'b0, 1'b0, 1'b1, NONE},
    // Full-mask error on the top qubit, both components.
    '{F_ERROR,   8'd255, 8'd0,   ONES, 1'b1, 1'b1, 1'b0, NONE},
    '{F_MX,      8'd255, 8'd0,   NONE, 1'b0, 1'b0, 1'b1, ONES},
    '{F_MZ,      8'd255, 8'd0,   NONE, 1'b0, 1'b0, 1'b1, ONES},
    '{F_MY,      8'd255, 8'd0,   NONE, 1'b0, 1'b0, 1'b1, NONE},
    // X-only error, then measure-and-reset in Z clears it.
    '{F_ERROR,   8'd0,   8'd255, ALT,  1'b1, 1'b0, 1'b0, NONE},
    '{F_MRZ,     8'd0,   8'd0,   NONE, 1'b0, 1'b0, 1'b1, ALT},
    '{F_MZ,      8'd0,   8'd0,   NONE, 1'b0, 1'b0, 1'b1, NONE},
    '{F_ERROR,   8'd1,   8'd0,   HI,   1'b1, 1'b0, 1'b0, NONE},
    '{F_ERROR,   8'd2,   8'd0,   ALT,  1'b0, 1'b1, 1'b0, NONE},
    // Single-qubit Cliffords.
    '{F_H,       8'd1,   8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_H_XY,    8'd2,   8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_H_YZ,    8'd1,   8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_C_XYZ,   8'd2,   8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_C_ZYX,   8'd1,   8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    // Two-qubit gates, both orders, plus two same-qubit cases.
    '{F_CX,      8'd1,   8'd2,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_CY,      8'd2,   8'd1,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_CZ,      8'd1,   8'd255, NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_XCX,     8'd255, 8'd2,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_XCY,     8'd1,   8'd2,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_XCZ,     8'd2,   8'd1,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_YCX,     8'd1,   8'd2,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_YCY,     8'd2,   8'd255, NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_YCZ,     8'd1,   8'd2,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_SQRT_XX, 8'd2,   8'd1,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_SQRT_YY, 8'd1,   8'd2,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_SQRT_ZZ, 8'd255, 8'd1,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_SWAP,    8'd2,   8'd2,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_ISWAP,   8'd1,   8'd2,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_CXSWAP,  8'd1,   8'd1,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_SWAPCX,  8'd2,   8'd1,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    // Measure-and-reset, resets and a nop.
    '{F_MRX,     8'd1,   8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_MRY,     8'd2,   8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_RX,      8'd1,   8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_RY,      8'd2,   8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_RZ,      8'd255, 8'd0,   NONE, 1'b0, 1'b0, 1'b0, NONE},
    '{F_NOP,     8'd1,   8'd2,   ONES, 1'b1, 1'b1, 1'b0, NONE}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [8*IN_BYTES-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [8*OUT_BYTES-1:0] m_tdata;

  // Frame model state, one X and one Z word per qubit.
  word_t x_words [QUBIT_COUNT];
  word_t z_words [QUBIT_COUNT];
  meas_t pending_meas [$];

  // Pinned result for the item currently offered on the input side.
  bit    pin_valid = 1'b0;
  word_t pin_flips = '0;
  // When set, neither side idles.
  bit    steady = 1'b0;

  int mismatches = 0;
  int items_taken = 0;
  int results_seen = 0;

  pauli_frame_clifford_update_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (x_words[q]) begin
      x_words[q] = '0;
      z_words[q] = '0;
    end
  end

  // Applies one gate to the frame model. Returns 1 when the gate is a
  // measurement, with its flip word in flips.
  function automatic bit apply_gate(item_t g, output word_t flips);
    word_t x1, z1, x2, z2, d, e, t, mask;
    bit    a_ok, b_ok;
    a_ok  = int'(g.qubit_a) < QUBIT_COUNT;
    b_ok  = int'(g.qubit_b) < QUBIT_COUNT;
    mask  = g.error_mask[BATCH-1:0];
    flips = '0;
    x1 = x_words[g.qubit_a];
    z1 = z_words[g.qubit_a];
    x2 = x_words[g.qubit_b];
    z2 = z_words[g.qubit_b];

    // Measurements always produce a result, even on a qubit that is out of range.
    if (g.func >= F_MX && g.func <= F_MRZ) begin
      if (a_ok) begin
        case (g.func)
          F_MX:    flips = z1;
          F_MY:    flips = x1 ^ z1;
          F_MZ:    flips = x1;
          F_MRX: begin
            flips = z1;
            z_words[g.qubit_a] = '0;
          end
          F_MRY: begin
            flips = x1 ^ z1;
            x_words[g.qubit_a] = z1;
          end
          default: begin
            flips = x1;
            x_words[g.qubit_a] = '0;
          end
        endcase
      end
      return 1'b1;
    end

    if (g.func >= F_CX && g.func <= F_SWAPCX) begin
      if (!(a_ok && b_ok)) return 1'b0;
      case (g.func)
        F_CX: begin
          z1 ^= z2; x2 ^= x1;
        end
        F_CY: begin
          z1 ^= x2 ^ z2; z2 ^= x1; x2 ^= x1;
        end
        F_CZ: begin
          z1 ^= x2; z2 ^= x1;
        end
        F_XCX: begin
          x1 ^= z2; x2 ^= z1;
        end
        F_XCY: begin
          x1 ^= x2 ^ z2; x2 ^= z1; z2 ^= z1;
        end
        F_XCZ: begin
          z2 ^= z1; x1 ^= x2;
        end
        F_YCX: begin
          x2 ^= x1 ^ z1; x1 ^= z2; z1 ^= z2;
        end
        F_YCY: begin
          d = x1 ^ z1;
          e = x2 ^ z2;
          x1 ^= e; z1 ^= e; x2 ^= d; z2 ^= d;
        end
        F_YCZ: begin
          z2 ^= x1 ^ z1; z1 ^= x2; x1 ^= x2;
        end
        F_SQRT_XX: begin
          d = z1 ^ z2;
          x1 ^= d; x2 ^= d;
        end
        F_SQRT_YY: begin
          d = x1 ^ z1 ^ x2 ^ z2;
          x1 ^= d; z1 ^= d; x2 ^= d; z2 ^= d;
        end
        F_SQRT_ZZ: begin
          d = x1 ^ x2;
          z1 ^= d; z2 ^= d;
        end
        F_SWAP: begin
          t = x1; x1 = x2; x2 = t;
          t = z1; z1 = z2; z2 = t;
        end
        F_ISWAP: begin
          d = x1 ^ x2;
          t = z1 ^ d; z1 = z2 ^ d; z2 = t;
          t = x1; x1 = x2; x2 = t;
        end
        F_CXSWAP: begin
          z2 ^= z1; z1 ^= z2; x1 ^= x2; x2 ^= x1;
        end
        default: begin
          z1 ^= z2; z2 ^= z1; x2 ^= x1; x1 ^= x2;
        end
      endcase
      // With the same qubit on both sides, the second write wins.
      x_words[g.qubit_a] = x1;
      z_words[g.qubit_a] = z1;
      x_words[g.qubit_b] = x2;
      z_words[g.qubit_b] = z2;
      return 1'b0;
    end

    if (!a_ok) return 1'b0;
    case (g.func)
      F_H: begin
        t = x1; x1 = z1; z1 = t;
      end
      F_H_XY:  z1 ^= x1;
      F_H_YZ:  x1 ^= z1;
      F_C_XYZ: begin
        x1 ^= z1; z1 ^= x1;
      end
      F_C_ZYX: begin
        z1 ^= x1; x1 ^= z1;
      end
      F_RX:    z1 = '0;
      F_RY:    x1 = z1;
      F_RZ:    x1 = '0;
      F_ERROR: begin
        if (g.error_on_x) x1 ^= mask;
        if (g.error_on_z) z1 ^= mask;
      end
      default: ;
    endcase
    x_words[g.qubit_a] = x1;
    z_words[g.qubit_a] = z1;
    return 1'b0;
  endfunction

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t  mismatch: %s", $realtime, msg);
  endtask

  // Offers one gate item, after a random number of idle cycles, and
  // returns at the falling edge that follows its acceptance.
  task automatic send_gate(item_t g, bit pinned, word_t flips);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= {{(8*IN_BYTES-IN_BITS){1'b0}}, g};
    pin_valid = pinned;
    pin_flips = flips;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Most picks land on a handful of qubits at both ends of the range, so
  // the frame builds up correlations; the rest spread over all qubits.
  function automatic logic [7:0] pick_qubit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(0, 5));
    if (r < 7) return 8'($urandom_range(250, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t random_gate();
    item_t g;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 14)      g.func = F_ERROR;
    else if (r < 36) g.func = func_t'(5'($urandom_range(F_MX, F_MRZ)));
    else if (r < 42) g.func = func_t'(5'($urandom_range(F_RX, F_RZ)));
    else if (r < 44) g.func = F_NOP;
    else             g.func = func_t'(5'($urandom_range(F_H, F_SWAPCX)));
    g.qubit_a    = pick_qubit();
    g.qubit_b    = ($urandom_range(0, 15) == 0) ? g.qubit_a : pick_qubit();
    g.error_mask = {$urandom(), $urandom()};
    g.error_on_x = 1'($urandom_range(0, 1));
    g.error_on_z = 1'($urandom_range(0, 1));
    return g;
  endfunction

  // Output side: random stalls, none during the steady stretch.
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Port watcher: checks each accepted result against the oldest pending
  // measurement, then runs each accepted gate through the frame model.
  always @(posedge clk) begin : watch_ports
    meas_t got, want;
    word_t f;
    item_t g;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.flips = m_tdata[63:0];
        got.qubit = m_tdata[71:64];
        results_seen++;
        if (pending_meas.size() == 0) begin
          flag($sformatf("unrequested result flips=%h qubit=%0d", got.flips, got.qubit));
        end else begin
          want = pending_meas.pop_front();
          if (got.flips !== want.flips)
            flag($sformatf("qubit %0d flips: wanted %h, got %h",
                           want.qubit, want.flips, got.flips));
          if (got.qubit !== want.qubit)
            flag($sformatf("measured qubit: wanted %0d, got %0d", want.qubit, got.qubit));
        end
      end
      if (s_tvalid && s_tready) begin
        g = item_t'(s_tdata[IN_BITS-1:0]);
        items_taken++;
        if (apply_gate(g, f)) begin
          if (pin_valid) f = pin_flips;
          pending_meas.push_back('{flips: f, qubit: g.qubit_a});
        end
      end
    end
  end

  initial begin : stimulus
    item_t g;
    int    wait_cycles;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      g.func       = SCRIPT[i].f;
      g.qubit_a    = SCRIPT[i].qa;
      g.qubit_b    = SCRIPT[i].qb;
      g.error_mask = SCRIPT[i].mask;
      g.error_on_x = SCRIPT[i].ex;
      g.error_on_z = SCRIPT[i].ez;
      send_gate(g, SCRIPT[i].pinned, SCRIPT[i].flips);
    end

    // Random gate stream; one stretch in the middle runs with no idling.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 250 && n < 400);
      send_gate(random_gate(), 1'b0, '0);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;
    pin_valid = 1'b0;

    while (pending_meas.size() != 0) @(posedge clk);
    // Drain: wait on, so that a stray extra result would still show up.
    wait_cycles = 20;
    repeat (wait_cycles) @(posedge clk);
    if (pending_meas.size() != 0)
      flag($sformatf("%0d measurement results never arrived", pending_meas.size()));

    $display("Ran %0d gate items (%0d scripted, %0d random) through the frame update.",
             items_taken, SCRIPT_LEN, RANDOM_ITEMS);
    $display("Checked %0d measurement results; %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS pauli_frame_clifford_update_top");
    end else begin
      $display("FAIL pauli_frame_clifford_update_top");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL pauli_frame_clifford_update_top");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pfcu_pkg.sv
rtl/pfcu_dp.sv
rtl/pfcu_ctrl.sv
rtl/pauli_frame_clifford_update_top.sv
tb/testbench.sv
